[design/olq_pkg.sv]
// Shared types, codes and constants of the ordered list queue engine.
// No dependencies; every other file of the block uses it by scoped names.
`default_nettype none

package olq_pkg;

  localparam int DEPTH_DEF = 64;

  localparam int OP_W   = 3;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 6;
  localparam int ST_W   = 2;
  localparam int ECNT_W = 7;

  localparam logic [OP_W-1:0] OP_APPEND   = 3'd0;
  localparam logic [OP_W-1:0] OP_POP_HEAD = 3'd1;
  localparam logic [OP_W-1:0] OP_READ     = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_VAL  = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL_POS  = 3'd4;

  localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;
  localparam logic [ST_W-1:0] ST_NOMATCH = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_READ_CAP,
    S_HEAD_CAP,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    RA_IDX,
    RA_IDX1,
    RA_CLAMP
  } raddr_sel_t;

  typedef struct packed {
    logic            item_load;
    logic            idx_load_pos;
    logic            idx_inc;
    logic            cnt_inc;
    logic            cnt_dec;
    logic            rv_capture;
    logic            st_set;
    logic [ST_W-1:0] st_code;
    logic            mem_we;
    logic            wr_append;
    raddr_sel_t      raddr_sel;
    logic            out_load;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            empty;
    logic            pos_ge_cnt;
    logic            last_idx;
    logic            match;
    logic            out_free;
  } stat_t;

endpackage

`default_nettype wire

[design/olq_ifs.sv]
// Valid/ready channel interfaces for the list operation and its result.
// Depends on olq_pkg for field widths.
`default_nettype none

interface olq_in_if;
  logic                              valid;
  logic                              ready;
  logic        [olq_pkg::OP_W-1:0]   op;
  logic signed [olq_pkg::VAL_W-1:0]  item_value;
  logic        [olq_pkg::POS_W-1:0]  position;

  modport source (output valid, output op, output item_value, output position, input ready);
  modport sink   (input valid, input op, input item_value, input position, output ready);
endinterface

interface olq_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [olq_pkg::VAL_W-1:0]  read_value;
  logic        [olq_pkg::ST_W-1:0]   status;
  logic        [olq_pkg::ECNT_W-1:0] entry_count;
  logic                              is_empty;

  modport source (output valid, output read_value, output status, output entry_count,
                  output is_empty, input ready);
  modport sink   (input valid, input read_value, input status, input entry_count,
                  input is_empty, output ready);
endinterface

`default_nettype wire

[design/olq_ctrl.sv]
// Sequencer of the list engine: decodes an operation and steps the datapath.
// Depends on olq_pkg (state_t, cmd_t, stat_t, codes).
`default_nettype none

module olq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire olq_pkg::stat_t stat,
  output olq_pkg::cmd_t       cmd
);

  olq_pkg::state_t state_r;
  olq_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= olq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.raddr_sel = olq_pkg::RA_IDX;
    in_ready  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      olq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.item_load = 1'b1;
          state_nxt     = olq_pkg::S_DECODE;
        end
      end
      olq_pkg::S_DECODE: begin
        state_nxt = olq_pkg::S_FIN;
        case (stat.op)
          olq_pkg::OP_APPEND: begin
            if (stat.full) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = olq_pkg::ST_FULL;
            end else begin
              cmd.mem_we    = 1'b1;
              cmd.wr_append = 1'b1;
              cmd.cnt_inc   = 1'b1;
            end
          end
          olq_pkg::OP_POP_HEAD: begin
            if (stat.empty) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = olq_pkg::ST_EMPTY;
            end else begin
              state_nxt = olq_pkg::S_HEAD_CAP;
            end
          end
          olq_pkg::OP_READ: begin
            if (stat.empty) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = olq_pkg::ST_EMPTY;
            end else begin
              cmd.raddr_sel = olq_pkg::RA_CLAMP;
              state_nxt     = olq_pkg::S_READ_CAP;
            end
          end
          olq_pkg::OP_DEL_VAL: begin
            if (stat.empty) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = olq_pkg::ST_EMPTY;
            end else begin
              state_nxt = olq_pkg::S_SCAN_CMP;
            end
          end
          olq_pkg::OP_DEL_POS: begin
            if (stat.empty) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = olq_pkg::ST_EMPTY;
            end else if (stat.pos_ge_cnt) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = olq_pkg::ST_NOMATCH;
            end else begin
              cmd.idx_load_pos = 1'b1;
              state_nxt        = olq_pkg::S_SHIFT_RD;
            end
          end
          default: begin
            cmd.st_set  = 1'b1;
            cmd.st_code = olq_pkg::ST_NOMATCH;
          end
        endcase
      end
      olq_pkg::S_READ_CAP: begin
        cmd.rv_capture = 1'b1;
        state_nxt      = olq_pkg::S_FIN;
      end
      olq_pkg::S_HEAD_CAP: begin
        // head word is out; close the gap from index zero
        cmd.rv_capture = 1'b1;
        state_nxt      = olq_pkg::S_SHIFT_RD;
      end
      olq_pkg::S_SCAN_RD: begin
        state_nxt = olq_pkg::S_SCAN_CMP;
      end
      olq_pkg::S_SCAN_CMP: begin
        if (stat.match) begin
          state_nxt = olq_pkg::S_SHIFT_RD;
        end else if (stat.last_idx) begin
          cmd.st_set  = 1'b1;
          cmd.st_code = olq_pkg::ST_NOMATCH;
          state_nxt   = olq_pkg::S_FIN;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = olq_pkg::S_SCAN_RD;
        end
      end
      olq_pkg::S_SHIFT_RD: begin
        if (stat.last_idx) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = olq_pkg::S_FIN;
        end else begin
          cmd.raddr_sel = olq_pkg::RA_IDX1;
          state_nxt     = olq_pkg::S_SHIFT_WR;
        end
      end
      olq_pkg::S_SHIFT_WR: begin
        cmd.mem_we  = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt   = olq_pkg::S_SHIFT_RD;
      end
      olq_pkg::S_FIN: begin
        // hold until the result register is free
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = olq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = olq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[design/olq_dp.sv]
// Datapath of the list engine: entry memory, count, index, item and result registers.
// Depends on olq_pkg (cmd_t, stat_t, widths, codes).
`default_nettype none

module olq_dp #(
  parameter int DEPTH = olq_pkg::DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic        [olq_pkg::OP_W-1:0]   in_op,
  input  wire logic signed [olq_pkg::VAL_W-1:0]  in_item_value,
  input  wire logic        [olq_pkg::POS_W-1:0]  in_position,
  input  wire olq_pkg::cmd_t                     cmd,
  output olq_pkg::stat_t                         stat,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [olq_pkg::VAL_W-1:0]       out_read_value,
  output logic        [olq_pkg::ST_W-1:0]        out_status,
  output logic        [olq_pkg::ECNT_W-1:0]      out_entry_count,
  output logic                                   out_is_empty
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > olq_pkg::POS_W) ? CW : olq_pkg::POS_W;

  logic [olq_pkg::VAL_W-1:0] mem [DEPTH];

  logic [olq_pkg::OP_W-1:0]   op_r;
  logic [olq_pkg::VAL_W-1:0]  val_r;
  logic [olq_pkg::POS_W-1:0]  pos_r;
  logic [AW-1:0]              idx_r;
  logic [CW-1:0]              count_r;
  logic [olq_pkg::VAL_W-1:0]  rv_r;
  logic [olq_pkg::ST_W-1:0]   st_r;
  logic [olq_pkg::VAL_W-1:0]  rdata_r;
  logic                       out_valid_r;
  logic [olq_pkg::VAL_W-1:0]  out_rv_r;
  logic [olq_pkg::ST_W-1:0]   out_st_r;
  logic [olq_pkg::ECNT_W-1:0] out_cnt_r;
  logic                       out_empty_r;

  logic [CMPW-1:0]           count_ext;
  logic [CMPW-1:0]           pos_ext;
  logic [CMPW-1:0]           idx1_ext;
  logic [CMPW-1:0]           clamp_ext;
  logic                      pos_ge;
  logic [AW-1:0]             raddr;
  logic [AW-1:0]             waddr;
  logic [olq_pkg::VAL_W-1:0] wdata;
  logic [CW+olq_pkg::ECNT_W-1:0] cnt_wide;

  assign count_ext = CMPW'(count_r);
  assign pos_ext   = CMPW'(pos_r);
  assign idx1_ext  = CMPW'(idx_r) + CMPW'(1);
  assign pos_ge    = (pos_ext >= count_ext);
  // a read past the end returns the last entry
  assign clamp_ext = pos_ge ? (count_ext - CMPW'(1)) : pos_ext;
  assign cnt_wide  = {{olq_pkg::ECNT_W{1'b0}}, count_r};

  always_comb begin
    case (cmd.raddr_sel)
      olq_pkg::RA_IDX:   raddr = idx_r;
      olq_pkg::RA_IDX1:  raddr = idx1_ext[AW-1:0];
      olq_pkg::RA_CLAMP: raddr = clamp_ext[AW-1:0];
      default:           raddr = idx_r;
    endcase
  end

  assign waddr = cmd.wr_append ? count_r[AW-1:0] : idx_r;
  assign wdata = cmd.wr_append ? val_r : rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.cnt_dec) begin
        count_r <= count_r - CW'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      op_r  <= in_op;
      val_r <= in_item_value;
      pos_r <= in_position;
      idx_r <= '0;
      rv_r  <= '0;
      st_r  <= olq_pkg::ST_DONE;
    end else begin
      if (cmd.idx_load_pos) begin
        idx_r <= AW'(pos_r);
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + AW'(1);
      end
      if (cmd.rv_capture) begin
        rv_r <= rdata_r;
      end
      if (cmd.st_set) begin
        st_r <= cmd.st_code;
      end
    end
    if (cmd.out_load) begin
      out_rv_r    <= rv_r;
      out_st_r    <= st_r;
      out_cnt_r   <= cnt_wide[olq_pkg::ECNT_W-1:0];
      out_empty_r <= (count_r == '0);
    end
  end

  assign stat.op         = op_r;
  assign stat.full       = (count_r == CW'(DEPTH));
  assign stat.empty      = (count_r == '0);
  assign stat.pos_ge_cnt = pos_ge;
  assign stat.last_idx   = (idx1_ext >= count_ext);
  assign stat.match      = (rdata_r == val_r);
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_rv_r;
  assign out_status      = out_st_r;
  assign out_entry_count = out_cnt_r;
  assign out_is_empty    = out_empty_r;

endmodule

`default_nettype wire

[design/ordered_list_queue_engine_core.sv]
// Top level of the ordered list queue engine: sequencer plus datapath.
// Depends on olq_pkg, olq_ifs (channel interfaces), olq_ctrl and olq_dp.
//
//   channel  | dir | beat contents
//   ---------+-----+-------------------------------------------------
//   in_ch    | in  | op, item_value, position
//   out_ch   | out | read_value, status, entry_count, is_empty
//
// Every operation passes through decode and a result state; read adds a capture state,
// remove head adds a head capture state, and the removes shift each later entry down one
// place; remove by value first scans from index zero for the first equal entry.
// The single-port entry memory moves one entry per shift read state and shift write state.
// Synchronous active-low reset clears the count; entries are undefined until written.
// A result waiting on out_ch does not block acceptance of the next beat.
`default_nettype none

module ordered_list_queue_engine_core #(
  parameter int DEPTH = olq_pkg::DEPTH_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  olq_in_if.sink    in_ch,
  olq_out_if.source out_ch
);

  olq_pkg::cmd_t  cmd;
  olq_pkg::stat_t stat;

  olq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  olq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_op           (in_ch.op),
    .in_item_value   (in_ch.item_value),
    .in_position     (in_ch.position),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_read_value  (out_ch.read_value),
    .out_status      (out_ch.status),
    .out_entry_count (out_ch.entry_count),
    .out_is_empty    (out_ch.is_empty)
  );

endmodule

`default_nettype wire

[design/olq_checker.sv]
// Port-level checks of the list engine's result channel, bound to the top level.
// Depends on olq_pkg for widths and status codes.
`default_nettype none

module olq_checker #(
  parameter int DEPTH = olq_pkg::DEPTH_DEF
) (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic signed [olq_pkg::VAL_W-1:0]  read_value,
  input wire logic        [olq_pkg::ST_W-1:0]   status,
  input wire logic        [olq_pkg::ECNT_W-1:0] entry_count,
  input wire logic                              is_empty
);

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(read_value) && $stable(status)
      && $stable(entry_count) && $stable(is_empty))
    else $error("result beat changed while stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (is_empty == (entry_count == '0)))
    else $error("empty flag disagrees with entry count");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == olq_pkg::ST_FULL |-> entry_count == olq_pkg::ECNT_W'(DEPTH))
    else $error("full status without a full list");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == olq_pkg::ST_EMPTY |-> is_empty)
    else $error("empty status on a non-empty list");

  a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != olq_pkg::ST_DONE |-> read_value == '0)
    else $error("nonzero value on a failed operation");

endmodule

bind ordered_list_queue_engine_core olq_checker #(
  .DEPTH (DEPTH)
) u_olq_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .read_value  (out_ch.read_value),
  .status      (out_ch.status),
  .entry_count (out_ch.entry_count),
  .is_empty    (out_ch.is_empty)
);

`default_nettype wire

[tb/tb_top.sv]
// Self-checking bench for ordered_list_queue_engine_core: list operations in, one result out.
// Uses olq_pkg and the olq_in_if/olq_out_if channel interfaces. Expected results come from
// a queue-based model of the list kept in lockstep with accepted beats.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import olq_pkg::*;

  localparam int LIST_DEPTH     = DEPTH_DEF;
  localparam int RANDOM_ITEMS   = 1650;
  localparam int HOLDOFF_ITEMS  = 200;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int STALL_LIMIT    = 4000;
  localparam int DRAIN_CYCLES   = 150;

  localparam logic [OP_W-1:0] OP_FIRST_UNUSED = OP_DEL_POS + 1'b1;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic [ST_W-1:0]         status;
    logic [ECNT_W-1:0]       entry_count;
    logic                    is_empty;
  } list_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  olq_in_if  in_ch();
  olq_out_if out_ch();

  ordered_list_queue_engine_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [VAL_W-1:0] list_model[$];
  list_result_t     expected_q[$];
  int               n_errors     = 0;
  int               stall_count  = 0;
  int               burst_left   = 0;
  int               holdoff_req  = 0;
  bit               sender_idle  = 1'b0;
  bit               recv_idle    = 1'b0;

  // Apply one operation to the list model and return the result it must produce.
  function automatic list_result_t apply_list_op(input logic [OP_W-1:0] op,
                                                 input logic [VAL_W-1:0] value,
                                                 input logic [POS_W-1:0] pos);
    list_result_t r;
    int n;
    int idx;
    r = '0;
    r.status = ST_DONE;
    n = list_model.size();
    if (op == OP_APPEND) begin
      if (n >= LIST_DEPTH) r.status = ST_FULL;
      else list_model.push_back(value);
    end else if (op > OP_DEL_POS) begin
      r.status = ST_NOMATCH;
    end else if (n == 0) begin
      r.status = ST_EMPTY;
    end else if (op == OP_POP_HEAD) begin
      r.read_value = list_model.pop_front();
    end else if (op == OP_READ) begin
      // clamp a read past the end to the tail entry
      idx = (int'(pos) >= n) ? n - 1 : int'(pos);
      r.read_value = list_model[idx];
    end else if (op == OP_DEL_VAL) begin
      idx = -1;
      for (int i = 0; i < n; i++) begin
        if (idx < 0 && list_model[i] == value) idx = i;
      end
      if (idx < 0) r.status = ST_NOMATCH;
      else list_model.delete(idx);
    end else begin
      if (int'(pos) >= n) r.status = ST_NOMATCH;
      else list_model.delete(int'(pos));
    end
    r.entry_count = ECNT_W'(list_model.size());
    r.is_empty    = (list_model.size() == 0);
    return r;
  endfunction

  // Offer one beat; returns at the edge where it is accepted.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value,
                           input logic [POS_W-1:0] pos);
    int gap;
    if (burst_left <= 0) begin
      gap = sender_idle ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.item_value <= value;
    in_ch.position   <= pos;
    do @(posedge clk); while (!in_ch.ready);
    expected_q.push_back(apply_list_op(op, value, pos));
    burst_left--;
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return {1'b1, {(VAL_W-1){1'b0}}};
      1:       return {1'b0, {(VAL_W-1){1'b1}}};
      2:       return '1;
      3, 4:    return VAL_W'($urandom_range(0, 7));   // small pool makes duplicates
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    if (list_model.size() > 0 && $urandom_range(0, 3) != 0)
      return POS_W'($urandom_range(0, list_model.size() - 1));
    return POS_W'($urandom_range(0, 2**POS_W - 1));
  endfunction

  task automatic send_random_item(input int grow_pct);
    int roll;
    logic [OP_W-1:0] op;
    logic [VAL_W-1:0] value;
    roll = $urandom_range(0, 99);
    if (roll < 2) op = OP_FIRST_UNUSED + OP_W'($urandom_range(0, 2));
    else if (roll < 2 + grow_pct) op = OP_APPEND;
    else op = OP_POP_HEAD + OP_W'($urandom_range(0, 3));
    if (op == OP_DEL_VAL && list_model.size() > 0 && $urandom_range(0, 3) != 0)
      value = list_model[$urandom_range(0, list_model.size() - 1)];
    else
      value = pick_value();
    send_item(op, value, pick_pos());
  endtask

  task automatic test_empty_list_ops();
    for (int k = OP_POP_HEAD; k <= OP_DEL_POS; k++)
      send_item(OP_W'(k), pick_value(), POS_W'($urandom_range(0, 2**POS_W - 1)));
    for (int k = OP_FIRST_UNUSED; k < 2**OP_W; k++)
      send_item(OP_W'(k), pick_value(), '0);
  endtask

  task automatic test_directed_ops();
    send_item(OP_APPEND, {1'b1, {(VAL_W-1){1'b0}}}, '0);
    send_item(OP_APPEND, {1'b0, {(VAL_W-1){1'b1}}}, '1);
    send_item(OP_APPEND, '0, '0);
    send_item(OP_APPEND, '1, '0);
    send_item(OP_APPEND, 32'h5A5A_A5A5, '0);
    send_item(OP_READ, '0, '0);
    send_item(OP_READ, '0, '1);           // past the end
    send_item(OP_READ, '0, POS_W'(2));
    send_item(OP_DEL_VAL, '0, '0);        // hits a middle entry
    send_item(OP_DEL_VAL, 32'd12345, '0); // nothing equal
    send_item(OP_DEL_POS, '0, '1);        // past the end
    send_item(OP_DEL_POS, '0, POS_W'(1));
    send_item(OP_FIRST_UNUSED, '1, '1);
    send_item(OP_POP_HEAD, '0, '0);
    send_item(OP_POP_HEAD, '0, '0);
    send_item(OP_POP_HEAD, '0, '0);
    send_item(OP_POP_HEAD, '0, '0);       // list is already empty here
  endtask

  task automatic test_random_traffic();
    int sent;
    int plen;
    int grow;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      plen = $urandom_range(20, 120);
      case ($urandom_range(0, 2))
        0:       grow = 75;
        1:       grow = 15;
        default: grow = 45;
      endcase
      sender_idle = ($urandom_range(0, 3) != 0);
      recv_idle   = ($urandom_range(0, 3) != 0);
      repeat (plen) begin
        send_random_item(grow);
        sent++;
      end
    end
  endtask

  task automatic test_receiver_holdoff();
    sender_idle = 1'b0;
    recv_idle   = 1'b1;
    holdoff_req++;
    repeat (HOLDOFF_ITEMS) send_random_item(50);
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.op         = OP_APPEND;
    in_ch.item_value = '0;
    in_ch.position   = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    sender_idle = 1'b1;
    recv_idle   = 1'b1;
    test_empty_list_ops();
    test_directed_ops();
    test_random_traffic();
    test_receiver_holdoff();

    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // Result side: random ready runs, ready held high, or a long hold-off on request.
  initial begin
    int run_left;
    int hold_left;
    int seen_req;
    bit level;
    run_left  = 0;
    hold_left = 0;
    seen_req  = 0;
    level     = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_req != seen_req) begin
        seen_req  = holdoff_req;
        hold_left = HOLDOFF_CYCLES;
      end
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (!recv_idle) begin
        out_ch.ready <= 1'b1;
      end else begin
        if (run_left <= 0) begin
          level    = ~level;
          run_left = level ? $urandom_range(1, 15) : $urandom_range(1, 8);
        end
        out_ch.ready <= level;
        run_left--;
      end
    end
  end

  always @(posedge clk) begin : check_results
    list_result_t got;
    list_result_t exp;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.read_value  = out_ch.read_value;
      got.status      = out_ch.status;
      got.entry_count = out_ch.entry_count;
      got.is_empty    = out_ch.is_empty;
      if (expected_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected beat: value=%0d status=%0d count=%0d empty=%0b", $time,
                 got.read_value, got.status, got.entry_count, got.is_empty);
      end else begin
        exp = expected_q.pop_front();
        if (got !== exp) begin
          n_errors++;
          $display("%0t: expected v=%0d st=%0d n=%0d e=%0b, actual v=%0d st=%0d n=%0d e=%0b",
                   $time, exp.read_value, exp.status, exp.entry_count, exp.is_empty,
                   got.read_value, got.status, got.entry_count, got.is_empty);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_count <= 0;
    else
      stall_count <= stall_count + 1;
    if (stall_count >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule

`default_nettype wire
